// ===== src/insertion_sort_engine_core_defines.svh =====
// Assertion macros used by the checker file of the insertion sort engine.
`ifndef INSERTION_SORT_ENGINE_CORE_DEFINES_SVH
`define INSERTION_SORT_ENGINE_CORE_DEFINES_SVH

// Check that the consequent holds in the cycle after the antecedent.
`define ISE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ise: next-cycle check failed");

// Check that the consequent holds in the same cycle as the antecedent.
`define ISE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ise: same-cycle check failed");

`endif

// ===== src/ise_pkg.sv =====
// Package of the insertion sort engine: defaults, cell operations and cell control.
`timescale 1ns / 1ps

package ise_pkg;

   // Default store depth and element width
   localparam int DEPTH_DEF = 16;
   localparam int WIDTH_DEF = 32;

   // Operation applied to every cell of the chain in the same cycle
   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_SHIFT  = 2'd2
   } cell_op_type;

   // Control broadcast from the sequencer to the chain
   typedef struct packed {
      cell_op_type op;
   } cell_ctrl_type;

endpackage

// ===== src/insertion_sort_engine_core.sv =====
// Top level of the insertion sort engine: sequencer, fill count and result register.
//
//   channel  | ports                                        | handshake
//   ---------+----------------------------------------------+--------------------------
//   request  | req_value, req_last                          | start && !busy
//   response | rsp_sorted_value, rsp_last_out, rsp_dropped  | rsp_valid, one cycle each
//
// An item is inserted in the cycle it is accepted: every cell compares at once.
// A full store drops the item and flags its set. An item marked last drains the
// stored elements (1..DEPTH); busy is high meanwhile and results follow one a cycle.
// A new item may be accepted in the cycle the final result of a set is shown.
// Synchronous reset empties the store; the response side cannot stall.
`timescale 1ns / 1ps

module insertion_sort_engine_core #(
   parameter int WIDTH = ise_pkg::WIDTH_DEF,
   parameter int DEPTH = ise_pkg::DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [WIDTH - 1:0] req_value,
   input  logic                      req_last,
   output logic                      rsp_valid,
   output logic signed [WIDTH - 1:0] rsp_sorted_value,
   output logic                      rsp_last_out,
   output logic                      rsp_dropped
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW - 1:0] FULL = CW'(DEPTH);
   localparam logic [CW - 1:0] ONE  = CW'(1);

   typedef enum logic {
      ST_IDLE  = 1'b0,
      ST_DRAIN = 1'b1
   } state_type;

   state_type                 state_ff;
   logic [CW - 1:0]           count_ff;
   logic                      overflow_ff;
   logic                      rsp_valid_ff;
   logic signed [WIDTH - 1:0] rsp_sorted_value_ff;
   logic                      rsp_last_out_ff;
   logic                      rsp_dropped_ff;

   ise_pkg::cell_ctrl_type    ctrl;
   logic                      accept;
   logic                      full;
   logic signed [WIDTH - 1:0] head_value;

   assign accept = start && (state_ff == ST_IDLE);
   assign full   = count_ff == FULL;

   // Tell the chain what to do this cycle
   always_comb begin
      ctrl.op = ise_pkg::CELL_HOLD;
      if (state_ff == ST_DRAIN) begin
         ctrl.op = ise_pkg::CELL_SHIFT;
      end else if (accept && !full) begin
         ctrl.op = ise_pkg::CELL_INSERT;
      end
   end

   ise_chain #(
      .WIDTH (WIDTH),
      .DEPTH (DEPTH)
   ) u_chain (
      .clock      (clock),
      .ctrl       (ctrl),
      .fill_count (count_ff),
      .ins_value  (req_value),
      .head_value (head_value)
   );

   // Sequence inserts and drains; register each result for one cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (full) begin
                     overflow_ff <= 1'b1;
                  end else begin
                     count_ff <= count_ff + ONE;
                  end
                  if (req_last) begin
                     state_ff <= ST_DRAIN;
                  end
               end
            end
            ST_DRAIN: begin
               rsp_valid_ff        <= 1'b1;
               rsp_sorted_value_ff <= head_value;
               rsp_last_out_ff     <= count_ff == ONE;
               rsp_dropped_ff      <= overflow_ff;
               count_ff            <= count_ff - ONE;
               if (count_ff == ONE) begin
                  overflow_ff <= 1'b0;
                  state_ff    <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy             = state_ff == ST_DRAIN;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_sorted_value_ff;
   assign rsp_last_out     = rsp_last_out_ff;
   assign rsp_dropped      = rsp_dropped_ff;

endmodule

// ===== src/ise_cell.sv =====
// One cell of the sorting chain: holds a single element and trades with its neighbours.
`timescale 1ns / 1ps

module ise_cell #(
   parameter int WIDTH = ise_pkg::WIDTH_DEF,
   parameter int DEPTH = ise_pkg::DEPTH_DEF,
   parameter int INDEX = 0
) (
   input  logic                                clock,
   input  ise_pkg::cell_ctrl_type              ctrl,
   input  logic [$clog2(DEPTH + 1) - 1:0]      fill_count,
   input  logic signed [WIDTH - 1:0]           ins_value,
   input  logic signed [WIDTH - 1:0]           prev_value,
   input  logic                                prev_greater,
   input  logic signed [WIDTH - 1:0]           next_value,
   output logic signed [WIDTH - 1:0]           value,
   output logic                                greater
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW - 1:0] IDX = CW'(INDEX);

   logic signed [WIDTH - 1:0] value_ff;
   logic signed [WIDTH - 1:0] value_in;
   logic                      occupied;
   logic                      first_free;

   // Compare own element with the incoming one; equal stays put for stability
   assign occupied   = IDX < fill_count;
   assign first_free = IDX == fill_count;
   assign greater    = occupied && (value_ff > ins_value);

   // Pick the next element: move up, take the new one, or slide down on drain
   always_comb begin
      value_in = value_ff;
      unique case (ctrl.op)
         ise_pkg::CELL_INSERT: begin
            if (greater || first_free) begin
               value_in = prev_greater ? prev_value : ins_value;
            end
         end
         ise_pkg::CELL_SHIFT: begin
            value_in = next_value;
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   // Hold the element
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// ===== src/ise_chain.sv =====
// Row of sorting cells kept in ascending order, drained towards cell zero.
`timescale 1ns / 1ps

module ise_chain #(
   parameter int WIDTH = ise_pkg::WIDTH_DEF,
   parameter int DEPTH = ise_pkg::DEPTH_DEF
) (
   input  logic                                clock,
   input  ise_pkg::cell_ctrl_type              ctrl,
   input  logic [$clog2(DEPTH + 1) - 1:0]      fill_count,
   input  logic signed [WIDTH - 1:0]           ins_value,
   output logic signed [WIDTH - 1:0]           head_value
);

   logic signed [WIDTH - 1:0] cell_value [DEPTH];
   logic                      cell_greater [DEPTH];

   // Build the row; cell zero has no lower neighbour, the top cell no upper one
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [WIDTH - 1:0] prev_value;
      logic                      prev_greater;
      logic signed [WIDTH - 1:0] next_value;

      if (i == 0) begin : g_bottom
         assign prev_value   = '0;
         assign prev_greater = 1'b0;
      end else begin : g_inner_lo
         assign prev_value   = cell_value[i - 1];
         assign prev_greater = cell_greater[i - 1];
      end

      if (i == DEPTH - 1) begin : g_top
         assign next_value = cell_value[i];
      end else begin : g_inner_hi
         assign next_value = cell_value[i + 1];
      end

      ise_cell #(
         .WIDTH (WIDTH),
         .DEPTH (DEPTH),
         .INDEX (i)
      ) u_cell (
         .clock        (clock),
         .ctrl         (ctrl),
         .fill_count   (fill_count),
         .ins_value    (ins_value),
         .prev_value   (prev_value),
         .prev_greater (prev_greater),
         .next_value   (next_value),
         .value        (cell_value[i]),
         .greater      (cell_greater[i])
      );
   end

   assign head_value = cell_value[0];

endmodule

// ===== src/ise_checker.sv =====
// Port-level checks of the insertion sort engine, bound to the top level.
`timescale 1ns / 1ps
`include "insertion_sort_engine_core_defines.svh"

module ise_checker #(
   parameter int WIDTH = ise_pkg::WIDTH_DEF
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic signed [WIDTH - 1:0] req_value,
   input logic                      req_last,
   input logic                      rsp_valid,
   input logic signed [WIDTH - 1:0] rsp_sorted_value,
   input logic                      rsp_last_out,
   input logic                      rsp_dropped
);

   logic last_accept;
   logic mid_result;

   assign last_accept = start && !busy && req_last;
   assign mid_result  = rsp_valid && !rsp_last_out;

   // A last item always starts a drain
   `ISE_ASSERT_NEXT(a_last_starts_drain, clock, reset, last_accept, busy)
   // Every drain cycle yields a result
   `ISE_ASSERT_NEXT(a_drain_emits, clock, reset, busy, rsp_valid)
   // Results of a set come back to back with one dropped flag
   `ISE_ASSERT_NEXT(a_set_unbroken, clock, reset, mid_result,
                    rsp_valid && (rsp_dropped == $past(rsp_dropped)))
   // The final result leaves a gap and frees the request side
   `ISE_ASSERT_NEXT(a_gap_after_set, clock, reset, rsp_valid && rsp_last_out, !rsp_valid)
   `ISE_ASSERT_SAME(a_free_at_end, clock, reset, rsp_valid && rsp_last_out, !busy)

endmodule

bind insertion_sort_engine_core ise_checker #(
   .WIDTH (WIDTH)
) u_ise_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_value        (req_value),
   .req_last         (req_last),
   .rsp_valid        (rsp_valid),
   .rsp_sorted_value (rsp_sorted_value),
   .rsp_last_out     (rsp_last_out),
   .rsp_dropped      (rsp_dropped)
);

// ===== bench/tb_insertion_sort_engine_core.sv =====
// Self-checking bench for the insertion sort engine: signed sets in, sorted drain checked.
`timescale 1ns / 1ps

module tb_insertion_sort_engine_core;

   localparam int WIDTH         = ise_pkg::WIDTH_DEF;
   localparam int DEPTH         = ise_pkg::DEPTH_DEF;
   localparam int RESET_CYCLES  = 9;
   localparam int IDLE_LIMIT    = 600;
   localparam int RANDOM_ITEMS  = 425;
   localparam int MAX_REPORTS   = 10;
   localparam int SETTLE_CYCLES = DEPTH + 8;

   localparam logic signed [WIDTH - 1:0] VALUE_MIN = {1'b1, {(WIDTH - 1){1'b0}}};
   localparam logic signed [WIDTH - 1:0] VALUE_MAX = {1'b0, {(WIDTH - 1){1'b1}}};

   // One sorted element as the engine should present it
   typedef struct {
      logic signed [WIDTH - 1:0] sorted_value;
      logic                      last_out;
      logic                      dropped;
   } sorted_entry_type;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic signed [WIDTH - 1:0] req_value;
   logic                      req_last;
   logic                      rsp_valid;
   logic signed [WIDTH - 1:0] rsp_sorted_value;
   logic                      rsp_last_out;
   logic                      rsp_dropped;

   // Sorter mirror of the engine's store
   logic signed [WIDTH - 1:0] sort_mirror [DEPTH];
   int                        mirror_fill     = 0;
   bit                        mirror_overflow = 1'b0;
   sorted_entry_type          sorted_due_q [$];

   int fail_count   = 0;
   int random_items = 0;
   bit burst_mode   = 1'b0;

   insertion_sort_engine_core #(
      .WIDTH (WIDTH),
      .DEPTH (DEPTH)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_value        (req_value),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_out     (rsp_last_out),
      .rsp_dropped      (rsp_dropped)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void log_failure(string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
         $display("mismatch at %0t: %s", $realtime, msg);
      end
   endfunction

   // Insert one value after any equal entries; drop it when the store is full
   function automatic void insert_into_mirror(logic signed [WIDTH - 1:0] v);
      int pos;
      if (mirror_fill >= DEPTH) begin
         mirror_overflow = 1'b1;
         return;
      end
      pos = mirror_fill;
      while (pos > 0 && sort_mirror[pos - 1] > v) begin
         sort_mirror[pos] = sort_mirror[pos - 1];
         pos--;
      end
      sort_mirror[pos] = v;
      mirror_fill++;
   endfunction

   // Update the mirror for an accepted item and queue the drain it causes
   function automatic void sort_accepted_item(logic signed [WIDTH - 1:0] v, logic is_last);
      sorted_entry_type entry;
      insert_into_mirror(v);
      if (is_last) begin
         for (int k = 0; k < mirror_fill; k++) begin
            entry.sorted_value = sort_mirror[k];
            entry.last_out     = (k == mirror_fill - 1);
            entry.dropped      = mirror_overflow;
            sorted_due_q       = {sorted_due_q, entry};
         end
         mirror_fill     = 0;
         mirror_overflow = 1'b0;
      end
   endfunction

   // Compare the shown element with the oldest one due
   function automatic void check_sorted_result();
      sorted_entry_type due;
      if (sorted_due_q.size() == 0) begin
         log_failure($sformatf("element %0d shown with nothing due", rsp_sorted_value));
         return;
      end
      due = sorted_due_q.pop_front();
      if (rsp_sorted_value !== due.sorted_value) begin
         log_failure($sformatf("sorted_value expected %0d got %0d",
                               due.sorted_value, rsp_sorted_value));
      end
      if (rsp_last_out !== due.last_out) begin
         log_failure($sformatf("last_out expected %0b got %0b (value %0d)",
                               due.last_out, rsp_last_out, due.sorted_value));
      end
      if (rsp_dropped !== due.dropped) begin
         log_failure($sformatf("dropped expected %0b got %0b (value %0d)",
                               due.dropped, rsp_dropped, due.sorted_value));
      end
   endfunction

   // Check results before queueing new ones: a drain never starts in its own accept cycle
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            check_sorted_result();
         end
         if (start && !busy) begin
            sort_accepted_item(req_value, req_last);
         end
      end
   end

   // Stop the run when nothing moves for too long
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_valid) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   // Mostly short gaps, a few long ones, none in burst mode
   function automatic int pick_gap();
      int r;
      if (burst_mode) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // Full-range values, a narrow band for ties, and the range edges
   function automatic logic signed [WIDTH - 1:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return $urandom;
      end else if (r < 85) begin
         return $signed($urandom_range(0, 6)) - 3;
      end
      case ($urandom_range(0, 5))
         0: return VALUE_MIN;
         1: return VALUE_MAX;
         2: return VALUE_MIN + 1;
         3: return VALUE_MAX - 1;
         4: return '0;
         default: return '1;
      endcase
   endfunction

   // Drive one item at the falling edge and hold it until the engine takes it
   task automatic send_item(logic signed [WIDTH - 1:0] v, logic is_last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start     <= 1'b1;
      req_value <= v;
      req_last  <= is_last;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Hold the sender off until every element due has been shown
   task automatic wait_for_drain();
      @(negedge clock);
      start <= 1'b0;
      while (sorted_due_q.size() != 0) @(posedge clock);
   endtask

   task automatic send_set(int size);
      for (int i = 0; i < size; i++) begin
         send_item(pick_value(), i == size - 1);
      end
   endtask

   // One-element sets at both ends of the range
   task automatic test_single_values();
      send_item(VALUE_MIN, 1'b1);
      send_item(VALUE_MAX, 1'b1);
   endtask

   // Range edges out of order, with repeated values
   task automatic test_extremes_and_ties();
      send_item(VALUE_MAX, 1'b0);
      send_item('0, 1'b0);
      send_item(VALUE_MIN, 1'b0);
      send_item('0, 1'b0);
      send_item('1, 1'b0);
      send_item(VALUE_MAX, 1'b1);
   endtask

   // Fill the store in falling order, then lose the element marked last
   task automatic test_overflow();
      for (int i = 0; i < DEPTH; i++) begin
         send_item(100 - 7 * i, 1'b0);
      end
      send_item(VALUE_MIN, 1'b1);
   endtask

   // Random sets: mostly small, some exactly full, some overflowing
   task automatic test_random_sets();
      int r;
      int size;
      while (random_items < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            size = $urandom_range(1, 6);
         end else if (r < 75) begin
            size = $urandom_range(7, DEPTH - 2);
         end else if (r < 88) begin
            size = $urandom_range(DEPTH - 1, DEPTH);
         end else begin
            size = $urandom_range(DEPTH + 1, DEPTH + 4);
         end
         burst_mode = ($urandom_range(0, 3) == 0);
         send_set(size);
         random_items += size;
         if ($urandom_range(0, 19) == 0) begin
            wait_for_drain();
         end
      end
      burst_mode = 1'b0;
   endtask

   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_value = '0;
      req_last  = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_single_values();
      test_extremes_and_ties();
      test_overflow();
      wait_for_drain();
      test_random_sets();

      // Drop start, let the last drain finish, then let the engine sit idle
      @(negedge clock);
      start <= 1'b0;
      while (sorted_due_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (fail_count == 0 && sorted_due_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+src
src/ise_pkg.sv
src/ise_cell.sv
src/ise_chain.sv
src/insertion_sort_engine_core.sv
src/ise_checker.sv
bench/tb_insertion_sort_engine_core.sv
